// File: sv/dpcm_bitstream_audio_decoder_assert.svh
// Assertion macros for the decoder checker.
`ifndef DPCM_BITSTREAM_AUDIO_DECODER_ASSERT_SVH
`define DPCM_BITSTREAM_AUDIO_DECODER_ASSERT_SVH

// Same-cycle implication.
`define DPCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dpcm_pkg.sv
package dpcm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int RUN_W      = 9;
    localparam int BUF_W      = 24;
    localparam int BCNT_W     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL,
        REG_WIDE,
        REG_STEREO,
        REG_BLOCK,
        REG_LAST_BLOCK
    } t_reg_idx;

    localparam logic [2:0] CODE_REPEAT = 3'd0;
    localparam logic [2:0] CODE_BIG    = 3'd7;
    localparam logic [2:0] LEVEL_HIGH  = 3'd3;
    localparam logic [2:0] LEVEL_RUN   = 3'd5;
    localparam logic [2:0] MAX_CODES   = 3'd4;

    typedef struct packed {
        logic accept;
        logic commit;
        logic push;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic to_decode;
        logic can_decode;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// File: sv/dpcm_in_if.sv
interface dpcm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;
    logic       final_block;

    modport source (output valid, data_byte, block_start, final_block, input ready);
    modport sink (input valid, data_byte, block_start, final_block, output ready);
endinterface

// File: sv/dpcm_out_if.sv
interface dpcm_out_if import dpcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                channel;
    logic [RUN_W-1:0]    run_count;
    logic                block_done;
    logic                last_of_item;

    modport source (output valid, sample, channel, run_count, block_done, last_of_item,
                    input ready);
    modport sink (input valid, sample, channel, run_count, block_done, last_of_item,
                  output ready);
endinterface

// File: sv/dpcm_cfg_if.sv
interface dpcm_cfg_if import dpcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dpcm_ctrl.sv
module dpcm_ctrl import dpcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic {S_IDLE, S_DECODE} t_state;

    t_state     r_state, n_state;
    logic [2:0] r_codes, n_codes;
    logic       step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_codes = r_codes;
        o_cmd   = '0;
        step    = i_status.can_decode && (r_codes != MAX_CODES);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.to_decode) begin
                        n_state = S_DECODE;
                        n_codes = '0;
                    end
                end
            end
            S_DECODE: begin
                if (step) begin
                    if (!i_status.pend_valid || i_status.out_free) begin
                        o_cmd.commit = 1'b1;
                        o_cmd.push   = i_status.pend_valid;
                        n_codes      = r_codes + 3'd1;
                    end
                end else if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    // flush the held word, tagged as last of the byte
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_codes <= '0;
        end else begin
            r_state <= n_state;
            r_codes <= n_codes;
        end
    end

endmodule

// File: sv/dpcm_dpath.sv
module dpcm_dpath import dpcm_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_block_start,
    input  logic                  i_final_block,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [SAMPLE_W-1:0]   o_sample,
    output logic                  o_channel,
    output logic [RUN_W-1:0]      o_run_count,
    output logic                  o_block_done,
    output logic                  o_last_of_item
);

    localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int EW = (COUNT_WIDTH > RUN_W) ? COUNT_WIDTH : RUN_W;

    logic [2:0]             r_level;
    logic                   r_wide;
    logic                   r_stereo;
    logic [15:0]            r_blk;
    logic [15:0]            r_last_blk;

    logic [BUF_W-1:0]       r_buf;
    logic [BCNT_W-1:0]      r_cnt;
    logic [SAMPLE_W-1:0]    r_pred [2];
    logic                   r_tog;
    logic [COUNT_WIDTH-1:0] r_left;
    logic [2:0]             r_hdr;

    logic                   r_pend_valid;
    logic [SAMPLE_W-1:0]    r_pend_sample;
    logic                   r_pend_ch;
    logic [RUN_W-1:0]       r_pend_run;
    logic                   r_pend_done;

    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_out_sample;
    logic                   r_out_ch;
    logic [RUN_W-1:0]       r_out_run;
    logic                   r_out_done;
    logic                   r_out_last;

    // code decode
    logic                   hi;
    logic [2:0]             code;
    logic [3:0]             nbits;
    logic [3:0]             shift;
    logic [4:0]             len;
    logic                   off4;
    logic                   is_diff;
    logic                   is_zero;
    logic [7:0]             extra;
    logic                   complete;
    logic [9:0]             fld;
    logic [9:0]             topm;
    logic                   sign;
    logic [9:0]             mag;
    logic [SAMPLE_W-1:0]    delta;
    logic [SAMPLE_W-1:0]    pcur;
    logic [SAMPLE_W-1:0]    pnew;
    logic [RUN_W-1:0]       emit_raw;
    logic [EW-1:0]          emit_e;
    logic [EW-1:0]          left_e;
    logic [EW-1:0]          emit_s;
    logic [COUNT_WIDTH-1:0] left_new;

    // byte intake
    logic [2:0]             total;
    logic [2:0]             hdr_eff;
    logic [2:0]             idx_full;
    logic                   hch;
    logic [15:0]            cnt_src;
    logic [LW-1:0]          cnt_ext;
    logic [LW-1:0]          cnt_max;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    logic [BUF_W-1:0]       buf_app;

    always_comb begin
        hi      = (r_level >= LEVEL_HIGH);
        code    = r_buf[2:0];
        nbits   = 4'd0;
        shift   = 4'd0;
        len     = 5'd3;
        off4    = 1'b0;
        is_diff = 1'b0;
        is_zero = 1'b0;
        extra   = 8'd0;
        if (code == CODE_BIG) begin
            off4 = 1'b1;
            if (r_buf[3]) begin
                is_zero = 1'b1;
                len     = 5'd4;
            end else begin
                is_diff = 1'b1;
                nbits   = hi ? 4'd8 : 4'd8 - {1'b0, r_level};
                shift   = hi ? 4'd9 : 4'd9 + {1'b0, r_level};
                len     = 5'd4 + {1'b0, nbits};
            end
        end else if (code != CODE_REPEAT) begin
            is_diff = 1'b1;
            nbits   = hi ? 4'd3 + {1'b0, r_level} : 4'd5 - {1'b0, r_level};
            shift   = hi ? 4'd1 + {1'b0, code} : 4'd2 + {1'b0, code} + {1'b0, r_level};
            len     = 5'd3 + {1'b0, nbits};
        end else if (r_level == LEVEL_RUN && !r_stereo) begin
            if (!r_buf[3]) begin
                len = 5'd4;
            end else if (r_buf[5:4] != 2'd3) begin
                extra = {6'd0, r_buf[5:4]};
                len   = 5'd6;
            end else begin
                extra = r_buf[13:6];
                len   = 5'd14;
            end
        end
        // missing bits read as zero, so a short buffer always fails this compare
        complete = (r_cnt >= len);

        fld   = off4 ? r_buf[13:4] : r_buf[12:3];
        topm  = 10'd1 << (nbits - 4'd1);
        sign  = |(fld & topm);
        mag   = fld & (topm - 10'd1);
        delta = {6'd0, mag} << shift;
        pcur  = r_pred[r_tog];
        if (is_zero) begin
            pnew = '0;
        end else if (is_diff) begin
            pnew = sign ? pcur - delta : pcur + delta;
        end else begin
            pnew = pcur;
        end

        emit_raw = {1'b0, extra} + 9'd1;
        emit_e   = EW'(emit_raw);
        left_e   = EW'(r_left);
        emit_s   = (emit_e > left_e) ? left_e : emit_e;
        left_new = COUNT_WIDTH'(left_e - emit_s);
    end

    always_comb begin
        total    = 3'd1 << ({2'd0, r_stereo} + {2'd0, r_wide});
        hdr_eff  = i_block_start ? total : r_hdr;
        idx_full = total - hdr_eff;
        hch      = r_wide ? idx_full[1] : idx_full[0];
        cnt_src  = i_final_block ? r_last_blk : r_blk;
        cnt_ext  = LW'(cnt_src);
        cnt_max  = LW'({COUNT_WIDTH{1'b1}});
        cnt_sat  = (cnt_ext > cnt_max) ? {COUNT_WIDTH{1'b1}} : cnt_ext[COUNT_WIDTH-1:0];
        buf_app  = r_buf | (BUF_W'(i_data_byte) << r_cnt);
    end

    assign o_status.to_decode  = (hdr_eff == 3'd0) && (r_left != '0);
    assign o_status.can_decode = complete && (r_left != '0);
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= 3'd0;
            r_wide       <= 1'b1;
            r_stereo     <= 1'b0;
            r_blk        <= 16'd1;
            r_last_blk   <= 16'd0;
            r_buf        <= '0;
            r_cnt        <= '0;
            r_pred[0]    <= '0;
            r_pred[1]    <= '0;
            r_tog        <= 1'b0;
            r_left       <= '0;
            r_hdr        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_LEVEL:      r_level    <= i_cfg_data[2:0];
                    REG_WIDE:       r_wide     <= i_cfg_data[0];
                    REG_STEREO:     r_stereo   <= i_cfg_data[0];
                    REG_BLOCK:      r_blk      <= i_cfg_data;
                    REG_LAST_BLOCK: r_last_blk <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                if (i_block_start) begin
                    r_left <= cnt_sat;
                    r_buf  <= '0;
                    r_cnt  <= '0;
                    r_tog  <= 1'b0;
                end
                if (hdr_eff != 3'd0) begin
                    if (!r_wide) begin
                        r_pred[hch] <= {8'd0, i_data_byte};
                    end else if (idx_full[0]) begin
                        r_pred[hch][15:8] <= i_data_byte;
                    end else begin
                        r_pred[hch][7:0] <= i_data_byte;
                    end
                    r_hdr <= hdr_eff - 3'd1;
                end else if (r_left != '0) begin
                    r_buf <= buf_app;
                    r_cnt <= r_cnt + 5'd8;
                end
            end

            if (i_cmd.commit) begin
                r_pred[r_tog] <= pnew;
                r_left        <= left_new;
                if (left_new == '0) begin
                    r_buf <= '0;
                    r_cnt <= '0;
                end else begin
                    r_buf <= r_buf >> len;
                    r_cnt <= r_cnt - len;
                end
                if (r_stereo) begin
                    r_tog <= r_tog ^ emit_s[0];
                end
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pend_sample <= r_wide ? pnew : {8'd0, pnew[7:0]};
            r_pend_ch     <= r_tog;
            r_pend_run    <= emit_s[RUN_W-1:0];
            r_pend_done   <= (left_new == '0);
        end
        if (i_cmd.push) begin
            r_out_sample <= r_pend_sample;
            r_out_ch     <= r_pend_ch;
            r_out_run    <= r_pend_run;
            r_out_done   <= r_pend_done;
            r_out_last   <= i_cmd.push_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_channel      = r_out_ch;
    assign o_run_count    = r_out_run;
    assign o_block_done   = r_out_done;
    assign o_last_of_item = r_out_last;

endmodule

// File: sv/dpcm_bitstream_audio_decoder.sv
// channel  dir  fields                                           word
// i_in     in   data_byte, block_start, final_block              one compressed byte
// o_out    out  sample, channel, run_count, block_done, last_of_item  one decoded sample run
// i_cfg    in   index, data                                      one register write
//
// A byte is taken while the controller is idle; header bytes and ignored bytes need no decode.
// A data byte then decodes one code per cycle while the output register can take a word,
// up to four codes, then a final step tags the last word, all in the single shared code decoder.
// Reset is synchronous and active low; it clears control state and valid flags, not the
// held word data; no clearing pass. A full output register stalls decoding; the next
// byte waits until the byte's last word has been handed to the output register.
module dpcm_bitstream_audio_decoder import dpcm_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dpcm_in_if.sink    i_in,
    dpcm_out_if.source o_out,
    dpcm_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    dpcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    dpcm_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_data_byte    (i_in.data_byte),
        .i_block_start  (i_in.block_start),
        .i_final_block  (i_in.final_block),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_sample       (o_out.sample),
        .o_channel      (o_out.channel),
        .o_run_count    (o_out.run_count),
        .o_block_done   (o_out.block_done),
        .o_last_of_item (o_out.last_of_item)
    );

endmodule

// File: sv/dpcm_chk.sv
module dpcm_chk import dpcm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_sample,
    input logic                i_out_channel,
    input logic [RUN_W-1:0]    i_out_run_count,
    input logic                i_out_block_done,
    input logic                i_out_last
);

`include "dpcm_bitstream_audio_decoder_assert.svh"

    `DPCM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample) && $stable(i_out_channel) && $stable(i_out_run_count) && $stable(i_out_last), "output word changed while stalled")

    `DPCM_ASSERT_IMP(a_run_range, i_out_valid, i_out_run_count != 9'd0 && i_out_run_count <= 9'd256, "run count out of range")

    `DPCM_ASSERT_IMP(a_done_last, i_out_valid && i_out_block_done, i_out_last, "block end not last word of byte")

    `DPCM_ASSERT_IMP(a_busy_mid_byte, i_out_valid && !i_out_last, !i_in_ready, "input ready before byte fully decoded")

endmodule

bind dpcm_bitstream_audio_decoder dpcm_chk u_dpcm_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_sample     (o_out.sample),
    .i_out_channel    (o_out.channel),
    .i_out_run_count  (o_out.run_count),
    .i_out_block_done (o_out.block_done),
    .i_out_last       (o_out.last_of_item)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import dpcm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       block_start;
        logic       final_block;
    } t_in_byte;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
        logic [RUN_W-1:0]    run_count;
        logic                block_done;
        logic                last_of_item;
    } t_sample_word;

    logic i_clk;
    logic i_rst_n;

    dpcm_in_if  in_if ();
    dpcm_out_if out_if ();
    dpcm_cfg_if cfg_if ();

    dpcm_bitstream_audio_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // register copies
    int cur_level = 0;
    int cur_wide = 1;
    int cur_stereo = 0;
    int cur_block = 1;
    int cur_last = 0;

    // decoder state copy
    logic [23:0] dec_bits = '0;
    int          dec_nbits = 0;
    logic [15:0] dec_pred [2] = '{16'h0000, 16'h0000};
    logic        dec_chan = 1'b0;
    int          dec_left = 0;
    int          dec_hdr_left = 0;

    t_in_byte     byte_q [$];
    t_sample_word sample_q [$];
    bit           code_bits [$];
    t_in_byte     cur_byte;
    t_sample_word want_w;

    int n_queued = 0;
    int n_bytes = 0;
    int n_words = 0;
    int n_runs = 0;
    int n_settings = 0;
    int errs = 0;
    int stall_cnt = 0;

    function automatic int send_idle_pct();
        if (n_bytes < 140) return 16;
        if (n_bytes < 280) return 84;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_bytes < 140) return 84;
        if (n_bytes < 280) return 16;
        return 0;
    endfunction

    function automatic void add_delta(logic [23:0] f, int w, int sh);
        int top;
        int mag;
        top = 1 << (w - 1);
        mag = (int'(f) & (top - 1)) << sh;
        if ((int'(f) & top) != 0) dec_pred[dec_chan] = dec_pred[dec_chan] - mag[15:0];
        else dec_pred[dec_chan] = dec_pred[dec_chan] + mag[15:0];
    endfunction

    // length of the next complete code, 0 if it is still partial
    function automatic int next_code_len(output int run);
        int t;
        int w;
        int sh;
        run = 0;
        if (dec_nbits < 3) return 0;
        t = int'(dec_bits[2:0]);
        if (t == CODE_BIG) begin
            if (dec_nbits < 4) return 0;
            if (dec_bits[3]) begin
                dec_pred[dec_chan] = '0;
                return 4;
            end
            w = (cur_level >= LEVEL_HIGH) ? 8 : 8 - cur_level;
            sh = (cur_level >= LEVEL_HIGH) ? 9 : 9 + cur_level;
            if (dec_nbits < 4 + w) return 0;
            add_delta(dec_bits >> 4, w, sh);
            return 4 + w;
        end
        if (t != CODE_REPEAT) begin
            w = (cur_level >= LEVEL_HIGH) ? 3 + cur_level : 5 - cur_level;
            sh = (cur_level >= LEVEL_HIGH) ? 1 + t : 2 + t + cur_level;
            if (dec_nbits < 3 + w) return 0;
            add_delta(dec_bits >> 3, w, sh);
            return 3 + w;
        end
        if (cur_level == LEVEL_RUN && cur_stereo == 0) begin
            if (dec_nbits < 4) return 0;
            if (!dec_bits[3]) return 4;
            if (dec_nbits < 6) return 0;
            if (dec_bits[5:4] != 2'b11) begin
                run = int'(dec_bits[5:4]);
                return 6;
            end
            if (dec_nbits < 14) return 0;
            run = int'(dec_bits[13:6]);
            return 14;
        end
        return 3;
    endfunction

    task automatic predict_samples(input t_in_byte b);
        t_sample_word got [4];
        logic [31:0]  merged;
        int n;
        int len;
        int run;
        int emit;
        int total;
        int idx;
        int ch;
        n = 0;
        total = (cur_stereo != 0 ? 2 : 1) * (cur_wide != 0 ? 2 : 1);
        if (b.block_start) begin
            dec_left = b.final_block ? cur_last : cur_block;
            dec_bits = '0;
            dec_nbits = 0;
            dec_chan = 1'b0;
            dec_hdr_left = total;
        end
        if (dec_hdr_left > 0) begin
            idx = (total - dec_hdr_left) & 3;
            ch = ((cur_wide != 0) ? (idx >> 1) : idx) & 1;
            if (cur_wide == 0) dec_pred[ch] = {8'h00, b.data};
            else if ((idx & 1) != 0) dec_pred[ch][15:8] = b.data;
            else dec_pred[ch][7:0] = b.data;
            dec_hdr_left--;
        end else if (dec_left > 0) begin
            merged = {8'h00, dec_bits} | (32'(b.data) << dec_nbits);
            dec_bits = merged[23:0];
            dec_nbits += 8;
            while (dec_left > 0 && n < 4) begin
                len = next_code_len(run);
                if (len == 0) break;
                dec_bits = dec_bits >> len;
                dec_nbits -= len;
                emit = run + 1;
                if (emit > dec_left) emit = dec_left;
                got[n].sample = (cur_wide != 0) ? dec_pred[dec_chan]
                                                : {8'h00, dec_pred[dec_chan][7:0]};
                got[n].channel = dec_chan;
                got[n].run_count = emit[RUN_W-1:0];
                dec_left -= emit;
                got[n].block_done = (dec_left == 0);
                got[n].last_of_item = 1'b0;
                if (cur_stereo != 0) dec_chan = dec_chan ^ emit[0];
                n++;
            end
            if (dec_left == 0) begin
                dec_bits = '0;
                dec_nbits = 0;
            end
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) got[k].last_of_item = 1'b1;
                sample_q.push_back(got[k]);
            end
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                predict_samples(cur_byte);
                n_bytes++;
            end
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
                cur_byte = byte_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.data_byte <= cur_byte.data;
                in_if.block_start <= cur_byte.block_start;
                in_if.final_block <= cur_byte.final_block;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // sample word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (sample_q.size() == 0) begin
                    $error("sample word 0x%0h with nothing expected", out_if.sample);
                    errs++;
                end else begin
                    want_w = sample_q.pop_front();
                    check_field("sample", want_w.sample, out_if.sample);
                    check_field("channel", want_w.channel, out_if.channel);
                    check_field("run_count", want_w.run_count, out_if.run_count);
                    check_field("block_done", want_w.block_done, out_if.block_done);
                    check_field("last_of_item", want_w.last_of_item, out_if.last_of_item);
                    if (want_w.run_count > 1) n_runs++;
                end
                n_words++;
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic push_byte(input logic [7:0] d, input logic bs, input logic fb);
        t_in_byte b;
        b.data = d;
        b.block_start = bs;
        b.final_block = fb;
        byte_q.push_back(b);
        n_queued++;
    endtask

    task automatic put_bits(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) code_bits.push_back(v[i]);
    endtask

    // pack pending code bits LSB first, pad the tail with random bits
    task automatic flush_bits(input logic fb);
        logic [7:0] d;
        while (code_bits.size() > 0) begin
            for (int i = 0; i < 8; i++) begin
                if (code_bits.size() > 0) d[i] = code_bits.pop_front();
                else d[i] = 1'($urandom_range(1));
            end
            push_byte(d, 1'b0, fb);
        end
    endtask

    task automatic gen_block();
        logic fin;
        int want;
        int made;
        int hdr;
        int t;
        int esc;
        int r;
        fin = ($urandom_range(3) == 0);
        want = fin ? cur_last : cur_block;
        if (want > 40) want = $urandom_range(40, 1);
        else if (want > 1 && $urandom_range(4) == 0) want = $urandom_range(want - 1, 1);
        hdr = (cur_stereo != 0 ? 2 : 1) * (cur_wide != 0 ? 2 : 1);
        for (int i = 0; i < hdr; i++) push_byte(8'($urandom_range(255)), i == 0, fin);
        made = 0;
        while (made < want) begin
            t = $urandom_range(7);
            put_bits(t, 3);
            made++;
            if (t == CODE_BIG) begin
                esc = ($urandom_range(3) == 0);
                put_bits(esc, 1);
                if (esc == 0)
                    put_bits($urandom, (cur_level >= LEVEL_HIGH) ? 8 : 8 - cur_level);
            end else if (t != CODE_REPEAT) begin
                put_bits($urandom, (cur_level >= LEVEL_HIGH) ? 3 + cur_level : 5 - cur_level);
            end else if (cur_level == LEVEL_RUN && cur_stereo == 0) begin
                esc = $urandom_range(1);
                put_bits(esc, 1);
                if (esc != 0) begin
                    r = $urandom_range(3);
                    put_bits(r, 2);
                    if (r == 3) begin
                        r = $urandom_range(255);
                        put_bits(r, 8);
                    end
                    made += r;
                end
            end
        end
        if (want == 0) put_bits($urandom, 16);
        flush_bits(fin);
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(3, 1))
            push_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'($urandom_range(1)));
    endtask

    task automatic set_cfg(input int lv, input int wd, input int st, input int bk, input int lb);
        t_reg_idx ri;
        logic [CFG_DATA_W-1:0] d;
        ri = REG_LEVEL;
        repeat (5) begin
            case (ri)
                REG_LEVEL:  d = lv;
                REG_WIDE:   d = wd;
                REG_STEREO: d = st;
                REG_BLOCK:  d = bk;
                default:    d = lb;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= ri;
            cfg_if.data <= d;
            do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
            case (ri)
                REG_LEVEL:  cur_level = lv & 7;
                REG_WIDE:   cur_wide = wd & 1;
                REG_STEREO: cur_stereo = st & 1;
                REG_BLOCK:  cur_block = bk & 16'hFFFF;
                default:    cur_last = lb & 16'hFFFF;
            endcase
            ri = ri.next();
        end
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // all bytes taken, all words seen, then let trailing decode work finish
    task automatic wait_idle();
        do @(posedge i_clk); while (n_bytes != n_queued || sample_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int start;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.block_start = 1'b0;
        in_if.final_block = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_LEVEL;
        cfg_if.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: bytes before any block start are dropped
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // predictor 0x1234, then escape to zero ends the one-sample block
        push_byte(8'h34, 1'b1, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'h00, 1'b0, 1'b0);
        // predictor 0x8000 minus the largest level 0 type 1 step
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'hF9, 1'b0, 1'b0);
        wait_idle();

        // header cut short by a mode change, index wraps
        set_cfg(0, 1, 1, 1, 0);
        push_byte(8'hAA, 1'b1, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        wait_idle();
        set_cfg(0, 0, 0, 1, 0);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        wait_idle();

        // long run split over two bytes, clipped at the block end
        set_cfg(LEVEL_RUN, 0, 0, 3, 0);
        push_byte(8'h7E, 1'b1, 1'b0);
        push_byte(8'hF8, 1'b0, 1'b0);
        push_byte(8'h3F, 1'b0, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_cfg(0, 0, 0, 1, 0);
                1: set_cfg(7, 1, 1, 16'hFFFF, 16'hFFFF);
                2: set_cfg(LEVEL_RUN, 0, 0, $urandom_range(60, 1), $urandom_range(60));
                3: set_cfg(LEVEL_RUN, 1, 0, $urandom_range(60, 1), $urandom_range(60));
                4: set_cfg(6, 1, 1, $urandom_range(48, 1), $urandom_range(48));
                default: set_cfg($urandom_range(7), $urandom_range(1), $urandom_range(1),
                                 $urandom_range(48, 1), $urandom_range(48));
            endcase
            start = n_queued;
            while (n_queued - start < PHASE_BYTES) begin
                if ($urandom_range(9) == 0) gen_noise();
                else gen_block();
            end
            wait_idle();
        end

        $display("%0d bytes in, %0d sample words checked (%0d runs), %0d register settings",
                 n_bytes, n_words, n_runs, n_settings);
        if (errs == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errs);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/dpcm_pkg.sv
sv/dpcm_in_if.sv
sv/dpcm_out_if.sv
sv/dpcm_cfg_if.sv
sv/dpcm_ctrl.sv
sv/dpcm_dpath.sv
sv/dpcm_bitstream_audio_decoder.sv
sv/dpcm_chk.sv
tb/tb.sv
